[hdl/pbb_pkg.sv]
`timescale 1ns / 1ps
package pbb_pkg;

   localparam int NUM_AXES = 3;
   localparam int COORD_W  = 32;
   localparam int MARGIN_W = 31;
   localparam int CSR_IDX_W = 3;

   // operation carried by each beat
   typedef enum logic [1:0] {
      KIND_CONTAIN = 2'd0,
      KIND_WRAP    = 2'd1,
      KIND_IMAGE   = 2'd2
   } kind_type;

   // configuration register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CORNER_A_X = 3'd0,
      CSR_CORNER_A_Y = 3'd1,
      CSR_CORNER_A_Z = 3'd2,
      CSR_CORNER_B_X = 3'd3,
      CSR_CORNER_B_Y = 3'd4,
      CSR_CORNER_B_Z = 3'd5
   } csr_idx_type;

   // per-axis record that moves down the remainder pipeline
   typedef struct packed {
      kind_type                    kind;
      logic                        act;
      logic                        ge;
      logic                        lt;
      logic                        bad;
      logic signed [COORD_W-1:0]   p;
      logic signed [COORD_W-1:0]   lo;
      logic signed [COORD_W-1:0]   hi;
      logic [COORD_W-1:0]          ext;
      logic signed [COORD_W+1:0]   d;
      logic [COORD_W-1:0]          dvd;
      logic [COORD_W-1:0]          rem;
   } stage_type;

endpackage

[hdl/pbb_if.sv]
`timescale 1ns / 1ps
interface pbb_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          kind;
   logic signed [31:0]  coord_x;
   logic signed [31:0]  coord_y;
   logic signed [31:0]  coord_z;
   logic [30:0]         margin;

   modport source (output valid, kind, coord_x, coord_y, coord_z, margin, input ready);
   modport sink   (input valid, kind, coord_x, coord_y, coord_z, margin, output ready);
endinterface

interface pbb_rsp_if;
   logic                valid;
   logic                ready;
   logic signed [31:0]  result_x;
   logic signed [31:0]  result_y;
   logic signed [31:0]  result_z;
   logic                inside_res;

   modport source (output valid, result_x, result_y, result_z, inside_res, input ready);
   modport sink   (input valid, result_x, result_y, result_z, inside_res, output ready);
endinterface

[hdl/pbb_axis.sv]
`timescale 1ns / 1ps
module pbb_axis #(
   parameter int STEP_BITS = 4
) (
   input  logic                  clock,
   input  logic                  en,
   input  pbb_pkg::kind_type     kind,
   input  logic signed [31:0]    coord,
   input  logic [30:0]           margin,
   input  logic signed [31:0]    lo,
   input  logic signed [31:0]    hi,
   input  logic [31:0]           ext,
   output logic signed [31:0]    result,
   output logic                  bad
);
   import pbb_pkg::*;

   localparam int NDIV = COORD_W / STEP_BITS;

   stage_type st_ff [NDIV+1];
   stage_type st_in [NDIV+1];

   logic signed [COORD_W+1:0] p_w, lo_w, hi_w, lo_m, hi_m, ext_w;
   logic signed [COORD_W+1:0] diff_up, diff_dn;
   logic signed [COORD_W-1:0] res_in;
   logic signed [COORD_W-1:0] res_ff;
   logic                      bad_ff;

   // classify: bounds test, wrap direction, dividend, first image step
   always_comb begin
      p_w     = {{2{coord[31]}}, coord};
      lo_w    = {{2{lo[31]}}, lo};
      hi_w    = {{2{hi[31]}}, hi};
      ext_w   = $signed({2'b00, ext});
      lo_m    = lo_w - $signed({3'b000, margin});
      hi_m    = hi_w + $signed({3'b000, margin});
      diff_up = p_w - lo_w;
      diff_dn = lo_w - p_w;
      st_in[0].kind = kind;
      st_in[0].act  = (ext != '0);
      st_in[0].ge   = (coord >= hi);
      st_in[0].lt   = (coord < lo);
      st_in[0].bad  = (ext != '0) && ((p_w < lo_m) || (p_w > hi_m));
      st_in[0].p    = coord;
      st_in[0].lo   = lo;
      st_in[0].hi   = hi;
      st_in[0].ext  = ext;
      st_in[0].d    = ($signed({p_w, 1'b0}) >= $signed({1'b0, ext_w})) ? (p_w - ext_w) : p_w;
      st_in[0].dvd  = (coord >= hi) ? diff_up[COORD_W-1:0] : diff_dn[COORD_W-1:0];
      st_in[0].rem  = '0;
   end

   // restoring remainder, STEP_BITS dividend bits per stage
   genvar k;
   generate
      for (k = 0; k < NDIV; k++) begin : g_div
         always_comb begin
            stage_type        tmp;
            logic [COORD_W:0] acc;
            tmp = st_ff[k];
            for (int b = 0; b < STEP_BITS; b++) begin
               acc     = {tmp.rem, tmp.dvd[COORD_W-1]};
               tmp.dvd = {tmp.dvd[COORD_W-2:0], 1'b0};
               if (acc >= {1'b0, tmp.ext}) begin
                  acc = acc - {1'b0, tmp.ext};
               end
               tmp.rem = acc[COORD_W-1:0];
            end
            // second minimum-image step rides along in the first stage
            if (k == 0) begin
               if ($signed({tmp.d, 1'b0}) < -$signed({3'b000, tmp.ext})) begin
                  tmp.d = tmp.d + $signed({2'b00, tmp.ext});
               end
            end
            st_in[k+1] = tmp;
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i <= NDIV; i++) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   // result select
   always_comb begin
      res_in = st_ff[NDIV].p;
      case (st_ff[NDIV].kind)
         KIND_WRAP: begin
            if (st_ff[NDIV].act && st_ff[NDIV].ge) begin
               res_in = st_ff[NDIV].lo + $signed(st_ff[NDIV].rem);
            end else if (st_ff[NDIV].act && st_ff[NDIV].lt) begin
               res_in = (st_ff[NDIV].rem == '0) ? st_ff[NDIV].lo
                                                : st_ff[NDIV].hi - $signed(st_ff[NDIV].rem);
            end
         end
         KIND_IMAGE: begin
            if (st_ff[NDIV].act) begin
               res_in = st_ff[NDIV].d[COORD_W-1:0];
            end
         end
         default: res_in = st_ff[NDIV].p;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
         bad_ff <= st_ff[NDIV].bad;
      end
   end

   assign result = res_ff;
   assign bad    = bad_ff;

endmodule

[hdl/periodic_box_boundary_unit.sv]
`timescale 1ns / 1ps
// request beats pass input capture, bounds, classify, remainder and result registers
// throughput: one beat per cycle unless the output beat is held (pipelined remainder stages)
// each remainder stage resolves STEP_BITS quotient bits per axis
// reset: synchronous, active high; clears valid bits and all box corners to zero
module periodic_box_boundary_unit #(
   parameter int STEP_BITS = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [pbb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                     csr_wdata,
   pbb_req_if.sink                         req,
   pbb_rsp_if.source                       rsp
);
   import pbb_pkg::*;

   localparam int NDIV  = COORD_W / STEP_BITS;
   localparam int DEPTH = NDIV + 4;

   logic signed [COORD_W-1:0] corner_a_ff [NUM_AXES];
   logic signed [COORD_W-1:0] corner_b_ff [NUM_AXES];

   logic                      vld_ff  [DEPTH];
   kind_type                  kind_ff [DEPTH];
   logic                      en;

   logic signed [COORD_W-1:0] in_coord_ff [NUM_AXES];
   logic [MARGIN_W-1:0]       in_margin_ff;
   logic signed [COORD_W-1:0] s1_coord_ff [NUM_AXES];
   logic [MARGIN_W-1:0]       s1_margin_ff;
   logic signed [COORD_W-1:0] s1_lo_ff  [NUM_AXES];
   logic signed [COORD_W-1:0] s1_hi_ff  [NUM_AXES];
   logic [COORD_W-1:0]        s1_ext_ff [NUM_AXES];

   logic signed [COORD_W-1:0] bnd_lo  [NUM_AXES];
   logic signed [COORD_W-1:0] bnd_hi  [NUM_AXES];
   logic [COORD_W:0]          bnd_ext [NUM_AXES];
   logic signed [COORD_W-1:0] res     [NUM_AXES];
   logic [NUM_AXES-1:0]       bad;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            corner_a_ff[i] <= '0;
            corner_b_ff[i] <= '0;
         end
      end else if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_CORNER_A_X: corner_a_ff[0] <= csr_wdata;
            CSR_CORNER_A_Y: corner_a_ff[1] <= csr_wdata;
            CSR_CORNER_A_Z: corner_a_ff[2] <= csr_wdata;
            CSR_CORNER_B_X: corner_b_ff[0] <= csr_wdata;
            CSR_CORNER_B_Y: corner_b_ff[1] <= csr_wdata;
            CSR_CORNER_B_Z: corner_b_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sorted bounds and extent per axis
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         bnd_lo[i]  = (corner_a_ff[i] < corner_b_ff[i]) ? corner_a_ff[i] : corner_b_ff[i];
         bnd_hi[i]  = (corner_a_ff[i] < corner_b_ff[i]) ? corner_b_ff[i] : corner_a_ff[i];
         bnd_ext[i] = {bnd_hi[i][COORD_W-1], bnd_hi[i]} - {bnd_lo[i][COORD_W-1], bnd_lo[i]};
      end
   end

   // whole pipe moves unless the output beat is held
   assign en        = !vld_ff[DEPTH-1] || rsp.ready;
   assign req.ready = en;

   // valid and kind travel with the beat
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req.valid;
         for (int i = 1; i < DEPTH; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind_ff[0] <= kind_type'(req.kind);
         for (int i = 1; i < DEPTH; i++) begin
            kind_ff[i] <= kind_ff[i-1];
         end
      end
   end

   // input capture, then bounds stage
   always_ff @(posedge clock) begin
      if (en) begin
         in_coord_ff[0] <= req.coord_x;
         in_coord_ff[1] <= req.coord_y;
         in_coord_ff[2] <= req.coord_z;
         in_margin_ff   <= req.margin;
         s1_margin_ff   <= in_margin_ff;
         for (int i = 0; i < NUM_AXES; i++) begin
            s1_coord_ff[i] <= in_coord_ff[i];
            s1_lo_ff[i]    <= bnd_lo[i];
            s1_hi_ff[i]    <= bnd_hi[i];
            s1_ext_ff[i]   <= bnd_ext[i][COORD_W-1:0];
         end
      end
   end

   // one lane per axis
   genvar a;
   generate
      for (a = 0; a < NUM_AXES; a++) begin : g_axis
         pbb_axis #(.STEP_BITS(STEP_BITS)) u_axis (
            .clock  (clock),
            .en     (en),
            .kind   (kind_ff[1]),
            .coord  (s1_coord_ff[a]),
            .margin (s1_margin_ff),
            .lo     (s1_lo_ff[a]),
            .hi     (s1_hi_ff[a]),
            .ext    (s1_ext_ff[a]),
            .result (res[a]),
            .bad    (bad[a])
         );
      end
   endgenerate

   assign rsp.valid      = vld_ff[DEPTH-1];
   assign rsp.result_x   = res[0];
   assign rsp.result_y   = res[1];
   assign rsp.result_z   = res[2];
   assign rsp.inside_res = (kind_ff[DEPTH-1] == KIND_CONTAIN) && (bad == '0);

`ifndef ASSERT_OFF
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp.valid)
      else $error("response beat valid right after reset");

   a_inside_kind: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.inside_res |-> kind_ff[DEPTH-1] == KIND_CONTAIN)
      else $error("inside flag on a non-containment beat");

   a_wrap_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && kind_ff[DEPTH-1] == KIND_WRAP && bnd_ext[0] != '0
      |-> rsp.result_x >= bnd_lo[0] && rsp.result_x < bnd_hi[0])
      else $error("wrapped x outside the box");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.result_x))
      else $error("held response beat changed");
`endif

endmodule

[tb/pbb_tb_if.sv]
`timescale 1ns / 1ps
// channel interfaces for the testbench side are the RTL's own (pbb_req_if, pbb_rsp_if)
// this file only carries the stimulus row type shared by the testbench
package pbb_tb_pkg;
   import pbb_pkg::*;

   // one row of the directed table
   typedef struct {
      logic [1:0]          kind;
      logic signed [31:0]  cx;
      logic signed [31:0]  cy;
      logic signed [31:0]  cz;
      logic [30:0]         margin;
      logic                has_exp;
      logic signed [31:0]  ex;
      logic signed [31:0]  ey;
      logic signed [31:0]  ez;
      logic                ein;
   } dir_row_type;
endpackage

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
   import pbb_pkg::*;
   import pbb_tb_pkg::*;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               in_box;
   } box_result_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   pbb_req_if req ();
   pbb_rsp_if rsp ();

   periodic_box_boundary_unit u_top (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req(req.sink), .rsp(rsp.source)
   );

   // predictor copy of the box corners
   logic signed [31:0] corner_a [3];
   logic signed [31:0] corner_b [3];

   box_result_type pending_results [$];
   int          mismatch_count;
   int          result_count;
   int          send_idle_pct;
   int          recv_stall_pct;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // overall limit
   initial begin
      #4000000;
      $display("FAIL periodic_box_boundary_unit");
      $finish;
   end

   // wrap one coordinate into [lo, hi)
   function automatic longint wrap_coord(longint p, longint lo, longint hi, longint ext);
      longint r;
      if (p >= hi) begin
         p = p - ext;
         if (p >= hi) p = lo + (p - lo) % ext;
      end
      if (p < lo) begin
         p = p + ext;
         if (p < lo) begin
            r = (lo - p) % ext;
            p = (r == 0) ? lo : hi - r;
         end
      end
      return p;
   endfunction

   // minimum-image shift: at most one step down, then at most one step up
   function automatic longint image_coord(longint d, longint ext);
      if (2 * d >= ext) d = d - ext;
      if (2 * d < -ext) d = d + ext;
      return d;
   endfunction

   function automatic box_result_type predict_box(logic [1:0] kind, logic signed [31:0] cx,
         logic signed [31:0] cy, logic signed [31:0] cz, logic [30:0] margin);
      box_result_type res;
      longint c [3];
      longint lo, hi, ext, a, b, m;
      bit in_box;
      c[0] = cx; c[1] = cy; c[2] = cz;
      m = margin;
      in_box = 1'b1;
      for (int ax = 0; ax < 3; ax++) begin
         a = corner_a[ax];
         b = corner_b[ax];
         lo = (a < b) ? a : b;
         hi = (a < b) ? b : a;
         ext = hi - lo;
         if (ext != 0) begin
            case (kind)
               KIND_CONTAIN: begin
                  if (c[ax] < lo - m || c[ax] > hi + m) in_box = 1'b0;
               end
               KIND_WRAP:  c[ax] = wrap_coord(c[ax], lo, hi, ext);
               KIND_IMAGE: c[ax] = image_coord(c[ax], ext);
               default: ;
            endcase
         end
      end
      res.x = c[0][31:0];
      res.y = c[1][31:0];
      res.z = c[2][31:0];
      res.in_box = (kind == KIND_CONTAIN) && in_box;
      return res;
   endfunction

   // register write, idle block only; the caller drops the enable
   task automatic write_corner(csr_idx_type idx, logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx <= CSR_CORNER_A_Z) corner_a[idx] = value;
      else corner_b[idx - CSR_CORNER_B_X] = value;
   endtask

   task automatic set_box(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
         logic [31:0] bx, logic [31:0] by, logic [31:0] bz);
      write_corner(CSR_CORNER_A_X, ax);
      write_corner(CSR_CORNER_A_Y, ay);
      write_corner(CSR_CORNER_A_Z, az);
      write_corner(CSR_CORNER_B_X, bx);
      write_corner(CSR_CORNER_B_Y, by);
      write_corner(CSR_CORNER_B_Z, bz);
      csr_wr_en <= 1'b0;
   endtask

   // wait until every expected beat has come back, then let the pipe drain
   task automatic drain_results();
      req.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // send one beat, with random idle before it; expectation queued on acceptance
   task automatic send_beat(logic [1:0] kind, logic signed [31:0] cx, logic signed [31:0] cy,
         logic signed [31:0] cz, logic [30:0] margin, bit has_exp, box_result_type typed);
      box_result_type exp_res;
      if ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req.valid   <= 1'b1;
      req.kind    <= kind;
      req.coord_x <= cx;
      req.coord_y <= cy;
      req.coord_z <= cz;
      req.margin  <= margin;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      exp_res = predict_box(kind, cx, cy, cz, margin);
      if (has_exp && exp_res != typed) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("table row disagrees with predictor: kind %0d", kind);
      end
      pending_results.push_back(has_exp ? typed : exp_res);
   endtask

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(5))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return $signed($urandom_range(16, 0)) - 8;
         3: return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [30:0] rand_margin();
      case ($urandom_range(3))
         0: return 31'd0;
         1: return 31'h7fff_ffff;
         2: return 31'($urandom_range(32'h0002_0000));
         default: return 31'($urandom);
      endcase
   endfunction

   task automatic random_box();
      logic [31:0] v [6];
      for (int i = 0; i < 6; i++) begin
         case ($urandom_range(4))
            0: v[i] = 32'h8000_0000;
            1: v[i] = 32'h7fff_ffff;
            2: v[i] = $urandom_range(32'h0008_0000);
            default: v[i] = $urandom;
         endcase
      end
      // sometimes collapse an axis so it is inactive
      if ($urandom_range(3) == 0) v[3 + $urandom_range(2)] = v[$urandom_range(2)];
      for (int i = 0; i < 3; i++) if ($urandom_range(4) == 0) v[3 + i] = v[i];
      set_box(v[0], v[1], v[2], v[3], v[4], v[5]);
   endtask

   // response checker with random stall
   always @(posedge clock) begin
      box_result_type exp_res;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            result_count++;
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result beat: got %h %h %h %b",
                     rsp.result_x, rsp.result_y, rsp.result_z, rsp.inside_res);
            end else begin
               exp_res = pending_results.pop_front();
               if (rsp.result_x !== exp_res.x || rsp.result_y !== exp_res.y ||
                     rsp.result_z !== exp_res.z || rsp.inside_res !== exp_res.in_box) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: exp %h %h %h %b got %h %h %h %b",
                        exp_res.x, exp_res.y, exp_res.z, exp_res.in_box,
                        rsp.result_x, rsp.result_y, rsp.result_z, rsp.inside_res);
               end
            end
         end
         rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   dir_row_type directed [$];
   box_result_type typed;
   int phase_items;

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0; csr_index = '0; csr_wdata = '0;
      req.valid = 1'b0; req.kind = '0;
      req.coord_x = '0; req.coord_y = '0; req.coord_z = '0; req.margin = '0;
      rsp.ready = 1'b0;
      mismatch_count = 0; result_count = 0;
      send_idle_pct = 0; recv_stall_pct = 0;
      for (int i = 0; i < 3; i++) begin corner_a[i] = 0; corner_b[i] = 0; end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset the box is degenerate: everything inside, nothing moves
      directed = '{
         '{KIND_CONTAIN, 32'sh8000_0000, 32'sh7fff_ffff, 0, 31'd0, 1,
           32'sh8000_0000, 32'sh7fff_ffff, 0, 1},
         '{KIND_WRAP, 32'sh7fff_ffff, -5, 32'sh8000_0000, 31'h7fff_ffff, 1,
           32'sh7fff_ffff, -5, 32'sh8000_0000, 0},
         '{KIND_IMAGE, 32'sh1234_5678, 0, -1, 31'd0, 1, 32'sh1234_5678, 0, -1, 0},
         '{2'd3, 7, 8, 9, 31'd3, 1, 7, 8, 9, 0}
      };
      foreach (directed[i]) begin
         typed = '{directed[i].ex, directed[i].ey, directed[i].ez, directed[i].ein};
         send_beat(directed[i].kind, directed[i].cx, directed[i].cy, directed[i].cz,
            directed[i].margin, directed[i].has_exp, typed);
      end
      drain_results();

      // box [-1.0, 2.0) on x, swapped corners on y, full range on z
      set_box(32'hffff_0000, 32'h0003_0000, 32'h8000_0000,
              32'h0002_0000, 32'h0000_0000, 32'h7fff_ffff);
      directed = '{
         // exactly at hi wraps to lo; below lo lands on hi side; multi-extent
         '{KIND_WRAP, 32'sh0002_0000, 32'sh0003_0000, 32'sh7fff_ffff, 0, 0, 0, 0, 0, 0},
         '{KIND_WRAP, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 0, 0, 0, 0, 0, 0},
         '{KIND_WRAP, -32'sh0004_0000, -32'sh0003_0000, 0, 0, 0, 0, 0, 0, 0},
         '{KIND_WRAP, 32'sh0005_0000, 32'sh0006_0000, -1, 0, 0, 0, 0, 0, 0},
         '{KIND_WRAP, -32'sh0006_8000, 32'sh0001_0000, 1, 0, 0, 0, 0, 0, 0},
         // half-extent boundaries
         '{KIND_IMAGE, 32'sh0001_8000, 32'sh0001_8000, 32'sh7fff_ffff, 0, 0, 0, 0, 0, 0},
         '{KIND_IMAGE, -32'sh0001_8000, -32'sh0001_8001, 32'sh8000_0000, 0, 0, 0, 0, 0, 0},
         '{KIND_IMAGE, 32'sh7fff_ffff, 32'sh8000_0000, 0, 0, 0, 0, 0, 0, 0},
         // containment on the edges and with extreme margins
         '{KIND_CONTAIN, 32'sh0002_0000, 0, 0, 31'd0, 0, 0, 0, 0, 0},
         '{KIND_CONTAIN, 32'sh0002_0001, 0, 0, 31'd0, 0, 0, 0, 0, 0},
         '{KIND_CONTAIN, 32'sh8000_0000, 32'sh7fff_ffff, 0, 31'h7fff_ffff, 0, 0, 0, 0, 0},
         '{KIND_CONTAIN, -32'sh0001_0001, 0, 0, 31'd1, 0, 0, 0, 0, 0},
         '{2'd3, -1, -2, -3, 31'd0, 0, 0, 0, 0, 0}
      };
      foreach (directed[i])
         send_beat(directed[i].kind, directed[i].cx, directed[i].cy, directed[i].cz,
            directed[i].margin, 0, typed);
      drain_results();

      // random phases with different idle and stall mixes
      for (int ph = 0; ph < 12; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
         endcase
         random_box();
         phase_items = 125;
         for (int n = 0; n < phase_items; n++) begin
            send_beat($urandom_range(3) == 3 ? 2'd3 : 2'($urandom_range(2)),
               rand_coord(), rand_coord(), rand_coord(), rand_margin(), 0, typed);
            // sender holds off until the pipe is empty
            if (n == 60) begin
               req.valid <= 1'b0;
               while (pending_results.size() != 0) @(posedge clock);
            end
         end
         drain_results();
      end

      $display("covered %0d result beats over 14 box settings with idle and stall mixes",
         result_count);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("PASS periodic_box_boundary_unit");
      end else begin
         $display("%0d mismatches, %0d beats missing", mismatch_count,
            pending_results.size());
         $display("FAIL periodic_box_boundary_unit");
      end
      $finish;
   end
endmodule

[periodic_box_boundary_unit.f]
hdl/pbb_pkg.sv
hdl/pbb_if.sv
hdl/pbb_axis.sv
hdl/periodic_box_boundary_unit.sv
tb/pbb_tb_if.sv
tb/testbench.sv
